// ===== design/utf8_decode_cluster_mark_defines.svh =====
// ---------------------------------------------------------------------------
// UTF-8 decoder assertion macros
// Shared property wrappers for the port checker.
// ---------------------------------------------------------------------------
`ifndef UTF8_DECODE_CLUSTER_MARK_DEFINES_SVH
`define UTF8_DECODE_CLUSTER_MARK_DEFINES_SVH

// same-cycle implication, sampled on clk_i, quiet while in reset
`define UDCM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define UDCM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/udcm_pkg.sv =====
// ---------------------------------------------------------------------------
// UTF-8 decoder package
// Request types, byte classes and the scalar and cluster checks used by the decoder.
// ---------------------------------------------------------------------------
package udcm_pkg;

  localparam int unsigned CpWidth = 21;

  localparam logic [CpWidth-1:0] CpMax       = 21'h10FFFF;
  localparam logic [CpWidth-1:0] SurrLo      = 21'h00D800;
  localparam logic [CpWidth-1:0] SurrHi      = 21'h00DFFF;
  localparam logic [CpWidth-1:0] CombLo      = 21'h000300;
  localparam logic [CpWidth-1:0] CombHi      = 21'h00036F;
  localparam logic [CpWidth-1:0] CombExtLo   = 21'h001AB0;
  localparam logic [CpWidth-1:0] CombExtHi   = 21'h001AFF;
  localparam logic [CpWidth-1:0] CombSupLo   = 21'h001DC0;
  localparam logic [CpWidth-1:0] CombSupHi   = 21'h001DFF;
  localparam logic [CpWidth-1:0] VarSelLo    = 21'h00FE00;
  localparam logic [CpWidth-1:0] VarSelHi    = 21'h00FE0F;
  localparam logic [CpWidth-1:0] Zwj         = 21'h00200D;
  localparam logic [CpWidth-1:0] Min2Byte    = 21'h000080;
  localparam logic [CpWidth-1:0] Min3Byte    = 21'h000800;
  localparam logic [CpWidth-1:0] Min4Byte    = 21'h010000;

  localparam logic [2:0] Len1 = 3'd1;
  localparam logic [2:0] Len2 = 3'd2;
  localparam logic [2:0] Len3 = 3'd3;
  localparam logic [2:0] Len4 = 3'd4;

  typedef enum logic [2:0] {
    BC_ASCII,
    BC_CONT,
    BC_LEAD2,
    BC_LEAD3,
    BC_LEAD4,
    BC_INVALID
  } byte_class_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       text_end;
  } in_item_t;

  typedef struct packed {
    logic [CpWidth-1:0] code_point;
    logic [2:0]         byte_count;
    logic               starts_cluster;
  } out_item_t;

  // result of one decode step
  typedef struct packed {
    logic      emit;
    out_item_t item;
  } udcm_res_t;

  function automatic byte_class_e classify(input logic [7:0] b);
    byte_class_e c;
    priority if (b[7] == 1'b0)        c = BC_ASCII;
    else if (b[7:6] == 2'b10)         c = BC_CONT;
    else if (b[7:5] == 3'b110)        c = BC_LEAD2;
    else if (b[7:4] == 4'b1110)       c = BC_LEAD3;
    else if (b[7:3] == 5'b11110)      c = BC_LEAD4;
    else                              c = BC_INVALID;
    return c;
  endfunction

  function automatic logic scalar_ok(input logic [CpWidth-1:0] cp, input logic [2:0] cnt);
    logic ok;
    ok = 1'b1;
    if (cnt == Len2 && cp < Min2Byte) ok = 1'b0;
    if (cnt == Len3 && cp < Min3Byte) ok = 1'b0;
    if (cnt == Len4 && cp < Min4Byte) ok = 1'b0;
    if (cp >= SurrLo && cp <= SurrHi) ok = 1'b0;
    if (cp > CpMax)                   ok = 1'b0;
    return ok;
  endfunction

  function automatic logic joins_prev(input logic [CpWidth-1:0] prev,
                                      input logic [CpWidth-1:0] cp);
    logic j;
    j = (cp >= CombLo    && cp <= CombHi)    ||
        (cp >= CombExtLo && cp <= CombExtHi) ||
        (cp >= CombSupLo && cp <= CombSupHi) ||
        (cp >= VarSelLo  && cp <= VarSelHi)  ||
        (cp == Zwj);
    return j && (prev != '0);
  endfunction

endpackage

// ===== design/udcm_core.sv =====
// ---------------------------------------------------------------------------
// UTF-8 decoder core
// Sequence state, validation and cluster marking for one byte per step.
// ---------------------------------------------------------------------------
module udcm_core
  import udcm_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  in_item_t  item_i,
  output udcm_res_t res_o
);

  logic [CpWidth-1:0] partial_q, partial_d;
  logic [2:0]         expect_q, expect_d;
  logic [2:0]         seen_q, seen_d;
  logic [CpWidth-1:0] prev_q, prev_d;
  logic               start_q, start_d;

  byte_class_e        cls;
  logic               handled;
  logic [CpWidth-1:0] acc;
  logic [2:0]         seen_inc;

  always_comb begin
    cls       = classify(item_i.data_byte);
    handled   = 1'b0;
    acc       = {partial_q[CpWidth-7:0], item_i.data_byte[5:0]};
    seen_inc  = 3'(seen_q + 3'd1);
    partial_d = partial_q;
    expect_d  = expect_q;
    seen_d    = seen_q;
    prev_d    = prev_q;
    start_d   = start_q;
    res_o     = '0;

    if (expect_q != '0) begin
      if (cls == BC_CONT) begin
        handled = 1'b1;
        if (seen_inc >= expect_q) begin
          partial_d = '0;
          expect_d  = '0;
          seen_d    = '0;
          if (scalar_ok(acc, expect_q)) begin
            res_o.emit            = 1'b1;
            res_o.item.code_point = acc;
            res_o.item.byte_count = expect_q;
          end
        end else begin
          partial_d = acc;
          seen_d    = seen_inc;
        end
      end else begin
        // broken sequence: drop it and treat this byte as a lead
        partial_d = '0;
        expect_d  = '0;
        seen_d    = '0;
      end
    end

    if (!handled) begin
      unique case (cls)
        BC_ASCII: begin
          res_o.emit            = 1'b1;
          res_o.item.code_point = CpWidth'(item_i.data_byte);
          res_o.item.byte_count = Len1;
        end
        BC_LEAD2: begin
          partial_d = CpWidth'(item_i.data_byte[4:0]);
          expect_d  = Len2;
          seen_d    = Len1;
        end
        BC_LEAD3: begin
          partial_d = CpWidth'(item_i.data_byte[3:0]);
          expect_d  = Len3;
          seen_d    = Len1;
        end
        BC_LEAD4: begin
          partial_d = CpWidth'(item_i.data_byte[2:0]);
          expect_d  = Len4;
          seen_d    = Len1;
        end
        BC_CONT, BC_INVALID: begin
          // stray or illegal byte, dropped
        end
      endcase
    end

    if (res_o.emit) begin
      res_o.item.starts_cluster = start_q || !joins_prev(prev_q, res_o.item.code_point);
      prev_d  = res_o.item.code_point;
      start_d = 1'b0;
    end

    if (item_i.text_end) begin
      partial_d = '0;
      expect_d  = '0;
      seen_d    = '0;
      prev_d    = '0;
      start_d   = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q <= '0;
      expect_q  <= '0;
      seen_q    <= '0;
      prev_q    <= '0;
      start_q   <= 1'b1;
    end else if (step_i) begin
      partial_q <= partial_d;
      expect_q  <= expect_d;
      seen_q    <= seen_d;
      prev_q    <= prev_d;
      start_q   <= start_d;
    end
  end

endmodule

// ===== design/utf8_decode_cluster_mark.sv =====
// An accepted byte goes into the input register, then any code point it completes
// moves into the result register and raises out_valid_o. Throughput: one byte
// per cycle unless out_stall_i holds a full result register; the sequence
// state lives in the core and is updated in the same cycle the byte moves into
// the result register. Reset (rst_ni low, asynchronous) empties both registers,
// closes any open sequence and marks the start of a new text.
// ---------------------------------------------------------------------------
// UTF-8 decoder top level
// Valid/stall wrapper around the decode core with in and out registers.
// ---------------------------------------------------------------------------
module utf8_decode_cluster_mark
  import udcm_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  logic      in_valid_q;
  in_item_t  in_q;
  logic      out_valid_q;
  out_item_t out_q;
  logic      advance;
  logic      load;
  udcm_res_t res;

  // the result register frees up when empty or when taken this cycle
  assign advance    = !out_valid_q || !out_stall_i;
  assign load       = !in_valid_q || advance;
  assign in_stall_o = in_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (load) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  udcm_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (in_valid_q && advance),
    .item_i (in_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q && res.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q && res.emit) begin
      out_q <= res.item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== design/udcm_checker.sv =====
// ---------------------------------------------------------------------------
// UTF-8 decoder port checker
// Watches the top level ports; attached by bind.
// ---------------------------------------------------------------------------
`include "utf8_decode_cluster_mark_defines.svh"

module udcm_checker
  import udcm_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_data_o
);

  logic out_held;
  logic len_ok;
  logic cp_ok;

  assign out_held = out_valid_o && out_stall_i;
  assign len_ok   = out_data_o.byte_count == Len1 || out_data_o.byte_count == Len2 ||
                    out_data_o.byte_count == Len3 || out_data_o.byte_count == Len4;
  assign cp_ok    = out_data_o.code_point <= CpMax &&
                    (out_data_o.code_point < SurrLo || out_data_o.code_point > SurrHi) &&
                    (out_data_o.byte_count != Len1 || out_data_o.code_point < Min2Byte);

  `UDCM_ASSERT_NEXT(a_out_hold, out_held, out_valid_o, "result dropped while stalled")
  `UDCM_ASSERT_NEXT(a_out_stable, out_held, $stable(out_data_o), "stalled result changed")
  // back-pressure only ever comes from a full, stalled result register
  `UDCM_ASSERT_NOW(a_stall_cause, in_stall_o, out_held, "input stalled without cause")
  // results are legal scalars with a sane length
  `UDCM_ASSERT_NOW(a_scalar, out_valid_o, len_ok && cp_ok, "bad scalar")

endmodule

bind utf8_decode_cluster_mark udcm_checker u_udcm_checker (.*);

// ===== verif/udcm_monitor.sv =====
// ---------------------------------------------------------------------------
// UTF-8 decoder monitor
// Watches both channels, decodes every accepted request byte on its own and
// compares each result with the oldest decoded code point still due.
// ---------------------------------------------------------------------------
module udcm_monitor
  import udcm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  in_item_t    in_data_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  out_item_t   out_data_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  logic [CpWidth-1:0] seq_value;
  logic [2:0]         seq_len;
  logic [2:0]         seq_got;
  logic [CpWidth-1:0] last_cp;
  logic               text_fresh;
  out_item_t          decoded_q[$];
  int unsigned        mismatches;
  int unsigned        backlog;

  assign fail_count_o = mismatches;
  assign pending_o    = backlog;

  task automatic clear_text();
    seq_value  = '0;
    seq_len    = '0;
    seq_got    = '0;
    last_cp    = '0;
    text_fresh = 1'b1;
  endtask

  task automatic note_point(input logic [CpWidth-1:0] cp, input logic [2:0] len);
    out_item_t due;
    logic      is_mark;
    is_mark = cp inside {[CombLo:CombHi], [CombExtLo:CombExtHi], [CombSupLo:CombSupHi],
                         [VarSelLo:VarSelHi], Zwj};
    due.code_point     = cp;
    due.byte_count     = len;
    due.starts_cluster = text_fresh || (last_cp == '0) || !is_mark;
    decoded_q = {decoded_q, due};
    last_cp    = cp;
    text_fresh = 1'b0;
  endtask

  task automatic absorb(input in_item_t req);
    logic [7:0]  b;
    logic        taken;
    logic        ok;
    byte_class_e kind;
    b     = req.data_byte;
    taken = 1'b0;
    casez (b)
      8'b0???????: kind = BC_ASCII;
      8'b10??????: kind = BC_CONT;
      8'b110?????: kind = BC_LEAD2;
      8'b1110????: kind = BC_LEAD3;
      8'b11110???: kind = BC_LEAD4;
      default:     kind = BC_INVALID;
    endcase
    if (seq_len != '0) begin
      if (kind == BC_CONT) begin
        taken     = 1'b1;
        seq_value = {seq_value[CpWidth-7:0], b[5:0]};
        seq_got   = seq_got + 3'd1;
        if (seq_got >= seq_len) begin
          // overlong, surrogate and out-of-range values vanish silently
          ok = !((seq_len == Len2 && seq_value < Min2Byte) ||
                 (seq_len == Len3 && seq_value < Min3Byte) ||
                 (seq_len == Len4 && seq_value < Min4Byte) ||
                 (seq_value >= SurrLo && seq_value <= SurrHi) ||
                 (seq_value > CpMax));
          if (ok) note_point(seq_value, seq_len);
          seq_value = '0;
          seq_len   = '0;
          seq_got   = '0;
        end
      end else begin
        // sequence broken off; the byte is looked at again as a lead
        seq_value = '0;
        seq_len   = '0;
        seq_got   = '0;
      end
    end
    if (!taken) begin
      case (kind)
        BC_ASCII: note_point({13'd0, b}, Len1);
        BC_LEAD2: begin
          seq_value = {16'd0, b[4:0]};
          seq_len   = Len2;
          seq_got   = 3'd1;
        end
        BC_LEAD3: begin
          seq_value = {17'd0, b[3:0]};
          seq_len   = Len3;
          seq_got   = 3'd1;
        end
        BC_LEAD4: begin
          seq_value = {18'd0, b[2:0]};
          seq_len   = Len4;
          seq_got   = 3'd1;
        end
        default: ;
      endcase
    end
    if (req.text_end) clear_text();
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      clear_text();
      decoded_q.delete();
      mismatches = 0;
      backlog    = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (decoded_q.size() == 0) begin
          $error("unexpected result: code_point %h byte_count %0d starts_cluster %b",
                 out_data_i.code_point, out_data_i.byte_count, out_data_i.starts_cluster);
          mismatches++;
        end else begin
          want = decoded_q.pop_front();
          if (out_data_i.code_point !== want.code_point) begin
            $error("code_point: expected %h, got %h", want.code_point,
                   out_data_i.code_point);
            mismatches++;
          end
          if (out_data_i.byte_count !== want.byte_count) begin
            $error("byte_count: expected %0d, got %0d", want.byte_count,
                   out_data_i.byte_count);
            mismatches++;
          end
          if (out_data_i.starts_cluster !== want.starts_cluster) begin
            $error("starts_cluster: expected %b, got %b", want.starts_cluster,
                   out_data_i.starts_cluster);
            mismatches++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) absorb(in_data_i);
      backlog = decoded_q.size();
    end
  end

endmodule

// ===== verif/tb.sv =====
// ---------------------------------------------------------------------------
// UTF-8 decoder testbench
// Feeds directed corner bytes, then mostly well-formed random characters with
// broken, overlong and out-of-range ones mixed in, under random idling.
// ---------------------------------------------------------------------------
module tb;
  import udcm_pkg::*;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  in_item_t    in_data_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_item_t   out_data_o;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned sent        = 0;

  // {text_end, byte}
  logic [8:0] opening_bytes [25] = '{
    9'h000,                         // lowest ASCII, leaves a zero previous point
    9'h0CC, 9'h081,                 // mark after a zero point still starts a cluster
    9'h07F,
    9'h0CC, 9'h081,                 // mark after a nonzero point joins it
    9'h080,                         // stray continuation
    9'h0FF,                         // lead byte that can never be valid
    9'h0E2, 9'h041,                 // sequence broken by ASCII
    9'h0C0, 9'h080,                 // overlong two-byte form
    9'h0ED, 9'h0A0, 9'h080,         // surrogate
    9'h0F4, 9'h090, 9'h080, 9'h080, // above U+10FFFF
    9'h0E2, 9'h182,                 // cut short by end of text
    9'h0F0, 9'h09F, 9'h098, 9'h180  // four-byte point closing a text
  };

  logic [CpWidth-1:0] corner_points [20] = '{
    21'h0, 21'h7F, 21'h80, 21'h7FF, 21'h800, 21'hFFFF, 21'h10000, 21'h10FFFF,
    21'h2FF, 21'h370, 21'h1AAF, 21'h1B00, 21'h1DBF, 21'h1E00, 21'hFDFF,
    21'hFE10, 21'h200C, 21'h200E, 21'hD7FF, 21'hE000
  };

  always #10 clk_i = ~clk_i;

  utf8_decode_cluster_mark dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  udcm_monitor u_mon (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_i  (out_data_o),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // mostly short gaps, now and then a long one
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic push_byte(input logic [7:0] b, input logic last);
    int unsigned gap;
    gap = (((sent / 64) % 4) == 3) ? 0 : idle_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{data_byte: b, text_end: last};
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    sent++;
  endtask

  task automatic send_random_char();
    logic [CpWidth-1:0] cp;
    logic [7:0]         seq [4];
    int unsigned        len;
    int unsigned        pick;
    int unsigned        n;
    int                 end_at;
    pick = $urandom_range(0, 99);
    case ($urandom_range(0, 5))
      0: cp = CpWidth'($urandom_range(0, 'h7F));
      1: begin
        case ($urandom_range(0, 4))
          0: cp = CpWidth'($urandom_range(CombLo, CombHi));
          1: cp = CpWidth'($urandom_range(CombExtLo, CombExtHi));
          2: cp = CpWidth'($urandom_range(CombSupLo, CombSupHi));
          3: cp = CpWidth'($urandom_range(VarSelLo, VarSelHi));
          default: cp = Zwj;
        endcase
      end
      2: cp = corner_points[$urandom_range(0, 19)];
      3: cp = CpWidth'($urandom_range(0, 'h10FFFF));
      4: cp = CpWidth'($urandom_range('hD7F0, 'hE010));
      default: cp = CpWidth'($urandom_range(0, 'h7FF));
    endcase
    len = (cp < 'h80) ? 1 : (cp < 'h800) ? 2 : (cp < 'h10000) ? 3 : 4;
    if (pick < 8 && len < 4) begin
      len = $urandom_range(len + 1, 4);                 // overlong form
    end else if (pick >= 8 && pick < 12) begin
      cp  = CpWidth'($urandom_range('h110000, 'h1FFFFF));
      len = 4;
    end
    case (len)
      1: seq[0] = cp[7:0];
      2: seq[0] = {3'b110, cp[10:6]};
      3: seq[0] = {4'b1110, cp[15:12]};
      default: seq[0] = {5'b11110, cp[20:18]};
    endcase
    for (int k = 1; k < len; k++) seq[k] = {2'b10, 6'(cp >> (6 * (len - 1 - k)))};
    n = len;
    if (pick >= 12 && pick < 17 && len > 1) begin
      n = $urandom_range(1, len - 1);                   // truncated sequence
    end else if (pick >= 17 && pick < 21) begin
      seq[0] = 8'($urandom_range(0, 255));              // raw noise byte
      n      = 1;
    end
    end_at = ($urandom_range(0, 11) == 0) ? int'(n) - 1 : -1;
    for (int k = 0; k < n; k++) push_byte(seq[k], k == end_at);
  endtask

  // receiver: random stall, quiet stretches, and an occasional long hold-off
  initial begin
    int unsigned rounds;
    int unsigned dur;
    logic        hold;
    rounds = 0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      rounds++;
      if (rounds % 150 == 75) begin
        hold = 1'b1;
        dur  = 80;
      end else if (rounds % 150 >= 100) begin
        hold = 1'b0;
        dur  = 1;
      end else begin
        hold = ($urandom_range(0, 3) == 0);
        dur  = hold ? idle_len() + 1 : $urandom_range(1, 6);
      end
      out_stall_i <= hold;
      repeat (dur) @(negedge clk_i);
    end
  end

  initial begin
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    foreach (opening_bytes[i]) push_byte(opening_bytes[i][7:0], opening_bytes[i][8]);
    while (sent < 725) send_random_char();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
